### hdl/lyapunov_exponent_pixel_defines.svh
`ifndef LYAPUNOV_EXPONENT_PIXEL_DEFINES_SVH
`define LYAPUNOV_EXPONENT_PIXEL_DEFINES_SVH

`ifndef SYNTH
`define LEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lep check failed");
`define LEP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lep check failed");
`else
`define LEP_ASSERT_NEXT(lbl, ante, cons)
`define LEP_ASSERT_NOW(lbl, ante, cons)
`endif

`endif

### hdl/lep_pkg.sv
package lep_pkg;

  localparam int PatternMaxDef = 16;
  localparam int RoundBitsDef  = 12;
  localparam int PatternWidth  = 16;
  localparam int RoundReset    = 4000;

  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [21:0] SAT_TERM   = 22'h20_0000;
  localparam logic signed [21:0] TH_QUARTER = -22'sd16384;
  localparam logic signed [21:0] TH_FORTY   = -22'sd26214;

  localparam logic [2:0] COLOR_POS     = 3'd0;
  localparam logic [2:0] COLOR_QUARTER = 3'd2;
  localparam logic [2:0] COLOR_FORTY   = 3'd3;
  localparam logic [2:0] COLOR_LOW     = 3'd4;

  localparam logic [7:0] REG_PATTERN_BITS   = 8'd0;
  localparam logic [7:0] REG_PATTERN_LENGTH = 8'd1;
  localparam logic [7:0] REG_ROUND_COUNT    = 8'd2;
  localparam logic [7:0] REG_START_X        = 8'd3;

  typedef struct packed {
    logic       load;
    logic       mul_p;
    logic       mul_x;
    logic       mul_d;
    logic       sel_b;
    logic       norm;
    logic       sqr;
    logic [3:0] sq_bit;
    logic       acc;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } lep_cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic norm_top;
    logic out_busy;
  } lep_status_t;

endpackage

### hdl/lyapunov_exponent_pixel.sv
// Lyapunov exponent of one fractal pixel. Each input transfer carries the rates a and b;
// from start_x the logistic map runs round_count rounds over the pattern, one shared
// 32x31 multiplier doing the map and derivative, then a log2 by normalization and 16
// squarings (none when the derivative is zero); a pixel is the accept, the steps, the
// serial divide of the sum by the step count and the output load.
// One pixel is in work at a time; a new input is taken as soon as the previous result
// sits in the output register, even if it has not been taken yet.
`include "lyapunov_exponent_pixel_defines.svh"
module lyapunov_exponent_pixel #(
  parameter int PATTERN_MAX = lep_pkg::PatternMaxDef,
  parameter int ROUND_BITS  = lep_pkg::RoundBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // a_value[31:0], b_value[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // exponent[21:0], color_index[24:22], zero_derivative[25]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lep_pkg::*;

  logic [15:0] pattern_bits;
  logic [4:0]  pattern_length;
  logic [ROUND_BITS-1:0] round_count, rounds_eff;
  logic [30:0] start_x;
  logic [5:0]  len_eff;
  lep_cmd_t    cmd;
  lep_status_t status;
  logic [21:0] exponent;
  logic [2:0]  color_index;
  logic        zero_derivative;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bits   <= 16'd2;
      pattern_length <= 5'd2;
      round_count    <= ROUND_BITS'(RoundReset);
      start_x        <= 31'h2000_0000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_BITS:   pattern_bits   <= cfg_data[15:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[4:0];
        REG_ROUND_COUNT:    round_count    <= cfg_data[ROUND_BITS-1:0];
        REG_START_X:        start_x        <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pattern_length == 5'd0) len_eff = 6'd1;
    else if ({1'b0, pattern_length} > 6'(PATTERN_MAX)) len_eff = 6'(PATTERN_MAX);
    else len_eff = {1'b0, pattern_length};
  end

  assign rounds_eff = (round_count == '0) ? ROUND_BITS'(1) : round_count;

  lep_control #(.ROUND_BITS(ROUND_BITS)) u_control (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .pattern_bits (pattern_bits),
    .len_eff      (len_eff),
    .rounds_eff   (rounds_eff),
    .status       (status),
    .cmd          (cmd)
  );

  lep_datapath #(.ROUND_BITS(ROUND_BITS)) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .a_in            (s_tdata[31:0]),
    .b_in            (s_tdata[63:32]),
    .start_x         (start_x),
    .rounds_eff      (rounds_eff),
    .len_eff         (len_eff),
    .m_tready        (m_tready),
    .m_tvalid        (m_tvalid),
    .exponent        (exponent),
    .color_index     (color_index),
    .zero_derivative (zero_derivative),
    .status          (status)
  );

  assign m_tdata = {6'd0, zero_derivative, color_index, exponent};

  `LEP_ASSERT_NEXT(busy_after_in, s_tvalid && s_tready, !s_tready)
  `LEP_ASSERT_NOW(color_sign, m_tvalid, (color_index == COLOR_POS) == ($signed(exponent) > 22'sd0))
  `LEP_ASSERT_NOW(floor_without_zero, m_tvalid && !zero_derivative, $signed(exponent) >= -22'sd1966080)

endmodule

### hdl/lep_datapath.sv
module lep_datapath #(
  parameter int ROUND_BITS = lep_pkg::RoundBitsDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lep_pkg::lep_cmd_t      cmd,
  input  logic [31:0]            a_in,
  input  logic [31:0]            b_in,
  input  logic [30:0]            start_x,
  input  logic [ROUND_BITS-1:0]  rounds_eff,
  input  logic [5:0]             len_eff,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [21:0]            exponent,
  output logic [2:0]             color_index,
  output logic                   zero_derivative,
  output lep_pkg::lep_status_t   status
);
  import lep_pkg::*;

  localparam int StepW = ROUND_BITS + 6;
  localparam int SumW  = StepW + 22;

  logic [31:0] a_r, b_r, r, mag_m;
  logic [30:0] x, p, omx, d, mul_b;
  logic [31:0] mul_a, twox;
  logic [62:0] prod;
  logic [32:0] xn;
  logic [63:0] sq;
  logic [32:0] sqs;
  logic [4:0]  k;
  logic [15:0] frac;
  logic        mzero, zflag, neg;
  logic [5:0]  kd;
  logic [21:0] term;
  logic signed [SumW-1:0] sum;
  logic [SumW-1:0] q;
  logic [StepW-1:0] steps;
  logic [StepW:0] rem, shifted;
  logic [21:0] mean;
  logic [2:0]  color;

  assign r     = cmd.sel_b ? b_r : a_r;
  assign omx   = ONE_Q30 - x;
  assign twox  = {x, 1'b0};
  assign d     = (twox > {1'b0, ONE_Q30}) ? 31'(twox - {1'b0, ONE_Q30})
                                          : 31'({1'b0, ONE_Q30} - twox);
  assign mul_a = cmd.mul_p ? {1'b0, x} : r;
  assign mul_b = cmd.mul_p ? omx : (cmd.mul_x ? p : d);
  assign prod  = 63'(mul_a) * 63'(mul_b);
  assign xn    = prod[62:30];
  assign sq    = 64'(mag_m) * 64'(mag_m);
  assign sqs   = sq[63:31];
  assign kd    = {1'b0, k} - 6'd30;
  assign term  = mzero ? SAT_TERM : {kd, frac};
  assign shifted = {rem[StepW-1:0], q[SumW-1]};
  assign mean  = neg ? 22'(-q[21:0]) : q[21:0];

  always_comb begin
    if ($signed(mean) > 22'sd0) color = COLOR_POS;
    else if ($signed(mean) >= TH_QUARTER) color = COLOR_QUARTER;
    else if ($signed(mean) >= TH_FORTY) color = COLOR_FORTY;
    else color = COLOR_LOW;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r   <= a_in;
      b_r   <= b_in;
      x     <= (start_x > ONE_Q30) ? ONE_Q30 : start_x;
      sum   <= '0;
      zflag <= 1'b0;
      steps <= StepW'(rounds_eff) * StepW'(len_eff);
    end
    if (cmd.mul_p) p <= prod[60:30];
    if (cmd.mul_x) x <= (xn > {2'b0, ONE_Q30}) ? ONE_Q30 : xn[30:0];
    if (cmd.mul_d) begin
      mag_m <= prod[61:30];
      mzero <= (prod[61:30] == 32'd0);
      k     <= 5'd31;
      frac  <= '0;
    end
    if (cmd.norm) begin
      if (mag_m[31:28] == 4'd0) begin
        mag_m <= {mag_m[27:0], 4'd0};
        k     <= k - 5'd4;
      end else begin
        mag_m <= {mag_m[30:0], 1'b0};
        k     <= k - 5'd1;
      end
    end
    if (cmd.sqr) begin
      if (sqs[32]) begin
        mag_m <= sqs[32:1];
        frac  <= frac | (16'd1 << cmd.sq_bit);
      end else begin
        mag_m <= sqs[31:0];
      end
    end
    if (cmd.acc) begin
      sum   <= sum + SumW'($signed(term));
      zflag <= zflag | mzero;
    end
    if (cmd.div_init) begin
      neg <= sum[SumW-1];
      q   <= sum[SumW-1] ? SumW'(-sum) : SumW'(sum);
      rem <= '0;
    end
    if (cmd.div_step) begin
      if (shifted >= {1'b0, steps}) begin
        rem <= shifted - {1'b0, steps};
        q   <= {q[SumW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q   <= {q[SumW-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      exponent        <= mean;
      color_index     <= color;
      zero_derivative <= zflag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign status.mag_zero = mzero;
  assign status.norm_top = mag_m[31];
  assign status.out_busy = m_tvalid & ~m_tready;

endmodule

### hdl/lep_control.sv
module lep_control #(
  parameter int ROUND_BITS = lep_pkg::RoundBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           pattern_bits,
  input  logic [5:0]            len_eff,
  input  logic [ROUND_BITS-1:0] rounds_eff,
  input  lep_pkg::lep_status_t  status,
  output lep_pkg::lep_cmd_t     cmd
);
  import lep_pkg::*;

  localparam int SumW = ROUND_BITS + 28;
  localparam int DivW = $clog2(SumW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PMUL  = 4'd1;
  localparam logic [3:0] S_XMUL  = 4'd2;
  localparam logic [3:0] S_DMUL  = 4'd3;
  localparam logic [3:0] S_NORM  = 4'd4;
  localparam logic [3:0] S_SQR   = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd6;
  localparam logic [3:0] S_DINIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state, state_next;
  logic [4:0] j, j_next;
  logic [ROUND_BITS-1:0] rnd, rnd_next;
  logic [3:0] sq, sq_next;
  logic [DivW-1:0] dcnt, dcnt_next;
  logic last_j, last_rnd;

  assign last_j   = ({1'b0, j} == len_eff - 6'd1);
  assign last_rnd = (rnd == rounds_eff - ROUND_BITS'(1));
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    j_next     = j;
    rnd_next   = rnd;
    sq_next    = sq;
    dcnt_next  = dcnt;
    cmd        = '0;
    cmd.sel_b  = j[4] ? 1'b0 : pattern_bits[j[3:0]];
    cmd.sq_bit = sq;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          j_next     = '0;
          rnd_next   = '0;
          state_next = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd.mul_p  = 1'b1;
        state_next = S_XMUL;
      end
      S_XMUL: begin
        cmd.mul_x  = 1'b1;
        state_next = S_DMUL;
      end
      S_DMUL: begin
        cmd.mul_d  = 1'b1;
        state_next = S_NORM;
      end
      S_NORM: begin
        priority if (status.mag_zero) begin
          state_next = S_ACC;
        end else if (status.norm_top) begin
          sq_next    = 4'd15;
          state_next = S_SQR;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_SQR: begin
        cmd.sqr = 1'b1;
        sq_next = sq - 4'd1;
        if (sq == 4'd0) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_PMUL;
        if (last_j) begin
          j_next = '0;
          if (last_rnd) state_next = S_DINIT;
          else rnd_next = rnd + ROUND_BITS'(1);
        end else begin
          j_next = j + 5'd1;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        dcnt_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + DivW'(1);
        if (dcnt == DivW'(SumW - 1)) state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      rnd   <= '0;
      sq    <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      rnd   <= rnd_next;
      sq    <= sq_next;
      dcnt  <= dcnt_next;
    end
  end

endmodule
